FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/ism_pkg.sv
package ism_pkg;

  localparam int FracW  = 17;
  localparam int TolW   = 16;
  localparam int AlphaW = 19;
  localparam int NormW  = 18;
  localparam int DirW   = 5;
  localparam int DistW  = 20;
  localparam int CfgIdxW = 2;

  localparam logic [FracW-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CfgIdxW-1:0] REG_SURFACE_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOLERANCE     = 2'd1;

  localparam logic [FracW-1:0] SURFACE_LEVEL_RST = 17'd32768;
  localparam logic [TolW-1:0]  TOLERANCE_RST     = 16'd1;

  typedef enum logic [1:0] {
    SIDE_ON     = 2'd0,
    SIDE_LIQUID = 2'd1,
    SIDE_GAS    = 2'd2
  } side_t;

  localparam logic [1:0] MARK_GAS   = 2'd0;
  localparam logic [1:0] MARK_UNDEC = 2'd1;
  localparam logic [1:0] MARK_LIQ   = 2'd2;

  typedef struct packed {
    side_t             side;
    logic [DistW-1:0]  reach;
    logic              crossed;
  } pt_res_t;

endpackage

FILE: hdl/interface_side_marker_unit.sv
// interface side marker
// input channel: in_valid / in_stall, one cell point per transfer; points
//   come in pairs, in_is_second low for the first point of a pair (stored,
//   no result) and high for the second point (one result)
// result channel: out_valid / out_stall carrying out_marker_halves
//   (0 gas, 1 undecided, 2 liquid)
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 surface level, index 1 tolerance, other indexes ignored;
//   cfg_ready is always high
// result path: a second point passes the input register, which loads at the
//   transfer, and then the result register, which loads when it is free
// throughput: one point per cycle when not stalled; point evaluation and
//   pair decision sit in one combinational pass between the two registers
// reset: stored point cleared (on interface, distance 0, not crossed,
//   fraction 0), registers back to surface level 0.5 and tolerance 1 lsb
// stall: a held result keeps its value; in_stall rises only when the input
//   register holds a second point that cannot move into the result register
module interface_side_marker_unit
  import ism_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_is_second,
  input  logic [FracW-1:0]         in_call_fraction,
  input  logic [FracW-1:0]         in_cell_fraction,
  input  logic signed [AlphaW-1:0] in_plane_constant,
  input  logic                     in_plane_valid,
  input  logic signed [NormW-1:0]  in_normal_x,
  input  logic signed [NormW-1:0]  in_normal_y,
  input  logic signed [NormW-1:0]  in_normal_z,
  input  logic [DirW-1:0]          in_direction,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_marker_halves,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [FracW-1:0]         cfg_data
);

`include "assert_macros.svh"

  logic [FracW-1:0] surface_level_r;
  logic [TolW-1:0]  tolerance_r;

  logic                     s1_valid_r;
  logic                     s1_second_r;
  logic [FracW-1:0]         s1_call_r;
  logic [FracW-1:0]         s1_cell_r;
  logic signed [AlphaW-1:0] s1_alpha_r;
  logic                     s1_pvalid_r;
  logic signed [NormW-1:0]  s1_nx_r;
  logic signed [NormW-1:0]  s1_ny_r;
  logic signed [NormW-1:0]  s1_nz_r;
  logic [DirW-1:0]          s1_dir_r;

  side_t            fst_side_r;
  logic [DistW-1:0] fst_dist_r;
  logic             fst_crossed_r;
  logic [FracW-1:0] fst_fraction_r;

  logic       out_valid_r;
  logic [1:0] out_marker_r;

  logic       in_take;
  logic       s1_adv;
  logic       res_load;
  pt_res_t    pt;
  logic [FracW-1:0] hi;
  logic [1:0] marker_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_level_r <= SURFACE_LEVEL_RST;
      tolerance_r     <= TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SURFACE_LEVEL: surface_level_r <= cfg_data;
        REG_TOLERANCE:     tolerance_r     <= cfg_data[TolW-1:0];
        default: ;
      endcase
    end
  end

  // a first point leaves without needing the result register
  assign s1_adv   = s1_valid_r && (!s1_second_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign res_load = s1_adv && s1_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_second_r <= in_is_second;
      s1_call_r   <= in_call_fraction;
      s1_cell_r   <= in_cell_fraction;
      s1_alpha_r  <= in_plane_constant;
      s1_pvalid_r <= in_plane_valid;
      s1_nx_r     <= in_normal_x;
      s1_ny_r     <= in_normal_y;
      s1_nz_r     <= in_normal_z;
      s1_dir_r    <= in_direction;
    end
  end

  ism_point_eval u_eval (
    .cell_fraction  (s1_cell_r),
    .plane_constant (s1_alpha_r),
    .plane_valid    (s1_pvalid_r),
    .normal_x       (s1_nx_r),
    .normal_y       (s1_ny_r),
    .normal_z       (s1_nz_r),
    .direction      (s1_dir_r),
    .surface_level  (surface_level_r),
    .tolerance      (tolerance_r),
    .res            (pt)
  );

  assign hi = ONE_Q16 - {1'b0, tolerance_r};

  always_comb begin
    if (((fst_fraction_r < {1'b0, tolerance_r}) && (s1_call_r > hi)) ||
        ((fst_fraction_r > hi) && (s1_call_r < {1'b0, tolerance_r}))) begin
      // empty next to full cell
      marker_nxt = MARK_UNDEC;
    end else if (fst_side_r == pt.side) begin
      case (pt.side)
        SIDE_LIQUID: marker_nxt = MARK_LIQ;
        SIDE_ON:     marker_nxt = MARK_UNDEC;
        default:     marker_nxt = MARK_GAS;
      endcase
    end else if (fst_crossed_r && !pt.crossed) begin
      marker_nxt = (fst_side_r == SIDE_LIQUID) ? MARK_LIQ : MARK_GAS;
    end else if (!fst_crossed_r && pt.crossed) begin
      marker_nxt = (pt.side == SIDE_LIQUID) ? MARK_LIQ : MARK_GAS;
    end else if (!fst_crossed_r && !pt.crossed) begin
      marker_nxt = MARK_UNDEC;
    end else if (fst_dist_r > pt.reach) begin
      marker_nxt = (fst_side_r == SIDE_LIQUID) ? MARK_LIQ : MARK_GAS;
    end else begin
      marker_nxt = (pt.side == SIDE_LIQUID) ? MARK_LIQ : MARK_GAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_side_r     <= SIDE_ON;
      fst_dist_r     <= '0;
      fst_crossed_r  <= 1'b0;
      fst_fraction_r <= '0;
    end else if (s1_adv && !s1_second_r) begin
      fst_side_r     <= pt.side;
      fst_dist_r     <= pt.reach;
      fst_crossed_r  <= pt.crossed;
      fst_fraction_r <= s1_call_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_marker_r <= marker_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_marker_halves = out_marker_r;

  `ASSERT_SAME(a_marker_code, clk, rst_n, out_valid_r, out_marker_r != 2'd3)
  `ASSERT_SAME(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r && s1_second_r)
  `ASSERT_NEXT(a_second_gives_result, clk, rst_n, res_load, out_valid_r)
  `ASSERT_NEXT(a_first_stored, clk, rst_n, s1_adv && !s1_second_r,
               fst_fraction_r == $past(s1_call_r))

endmodule

FILE: hdl/ism_point_eval.sv
module ism_point_eval
  import ism_pkg::*;
(
  input  logic [FracW-1:0]         cell_fraction,
  input  logic signed [AlphaW-1:0] plane_constant,
  input  logic                     plane_valid,
  input  logic signed [NormW-1:0]  normal_x,
  input  logic signed [NormW-1:0]  normal_y,
  input  logic signed [NormW-1:0]  normal_z,
  input  logic [DirW-1:0]          direction,
  input  logic [FracW-1:0]         surface_level,
  input  logic [TolW-1:0]          tolerance,
  output pt_res_t                  res
);

  // d is carried in units of 2^-17: e = 2*alpha - sum(|n| * m), m in {0,1,2}
  localparam int EW = 23;

  logic [DirW-1:0]       dir_c;
  logic [DirW-1:0]       rem9;
  logic [1:0]            dg [3];
  logic [1:0]            mm [3];
  logic [NormW-1:0]      nabs [3];
  logic [NormW:0]        term [3];
  logic signed [NormW-1:0] nn [3];
  logic [1:0]            cnt;
  logic signed [EW-1:0]  e;
  logic signed [EW-1:0]  tol2;
  logic [EW-1:0]         e_abs;
  side_t                 side;

  assign nn[0] = normal_x;
  assign nn[1] = normal_y;
  assign nn[2] = normal_z;

  always_comb begin
    dir_c = (direction > 5'd26) ? 5'd13 : direction;
    if (dir_c >= 5'd18) begin
      dg[2] = 2'd2;
      rem9  = dir_c - 5'd18;
    end else if (dir_c >= 5'd9) begin
      dg[2] = 2'd1;
      rem9  = dir_c - 5'd9;
    end else begin
      dg[2] = 2'd0;
      rem9  = dir_c;
    end
    if (rem9 >= 5'd6) begin
      dg[1] = 2'd2;
      dg[0] = 2'(rem9 - 5'd6);
    end else if (rem9 >= 5'd3) begin
      dg[1] = 2'd1;
      dg[0] = 2'(rem9 - 5'd3);
    end else begin
      dg[1] = 2'd0;
      dg[0] = 2'(rem9);
    end
  end

  assign cnt = 2'(dg[0] != 2'd1) + 2'(dg[1] != 2'd1) + 2'(dg[2] != 2'd1);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mm[a] = (cnt >= 2'd2) ? dg[a] : 2'd1;
      // mirror position when the normal component points up
      if (!nn[a][NormW-1] && (nn[a] != '0)) mm[a] = 2'd2 - mm[a];
      nabs[a] = nn[a][NormW-1] ? NormW'(-nn[a]) : NormW'(nn[a]);
      case (mm[a])
        2'd0:    term[a] = '0;
        2'd1:    term[a] = {1'b0, nabs[a]};
        2'd2:    term[a] = {nabs[a], 1'b0};
        default: term[a] = '0;
      endcase
    end
  end

  assign e = {{(EW-AlphaW-1){plane_constant[AlphaW-1]}}, plane_constant, 1'b0}
             - {{(EW-NormW-1){1'b0}}, term[0]}
             - {{(EW-NormW-1){1'b0}}, term[1]}
             - {{(EW-NormW-1){1'b0}}, term[2]};
  assign tol2 = {{(EW-TolW-1){1'b0}}, tolerance, 1'b0};
  assign e_abs = e[EW-1] ? EW'(-e) : EW'(e);

  always_comb begin
    if (!plane_valid) begin
      side        = (cell_fraction > surface_level) ? SIDE_LIQUID : SIDE_GAS;
      res.reach   = '0;
      res.crossed = 1'b0;
    end else begin
      if (e > tol2)       side = SIDE_LIQUID;
      else if (e < -tol2) side = SIDE_GAS;
      else                side = SIDE_ON;
      res.reach   = (side == SIDE_ON) ? '0 : e_abs[DistW:1];
      res.crossed = ((cell_fraction >= surface_level) && (side == SIDE_GAS)) ||
                    ((cell_fraction <= surface_level) && (side == SIDE_LIQUID));
    end
    res.side = side;
  end

endmodule
